/* rtl/core/fcps_pkg.sv */
// ----------------------------------------------------------------------------
// fcps_pkg
// Shared types and constants of the frame commanded pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fcps_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned NumBytes   = 17;

    localparam logic [10:0] ID_CTRL  = 11'h007;
    localparam logic [10:0] ID_MASK  = 11'b00000000111;
    localparam logic [10:0] ID_MODE1 = 11'b01110000000;
    localparam logic [10:0] ID_MODE2 = 11'b10110000000;
    localparam logic [10:0] ID_MODE3 = 11'b11010000000;
    localparam logic [10:0] ID_MODE4 = 11'b11100000000;

    localparam logic [7:0] CODE_SINGLE_A = 8'h0F;
    localparam logic [7:0] CODE_SINGLE_B = 8'hF0;
    localparam logic [7:0] CODE_START    = 8'hAA;
    localparam logic [7:0] CODE_PAUSE    = 8'hDD;
    localparam logic [7:0] CODE_ABORT    = 8'hFF;

    localparam logic [2:0] LINE_A = 3'b010;
    localparam logic [2:0] LINE_B = 3'b001;
    localparam logic [2:0] STROBE = 3'b100;

    typedef enum logic [1:0] {K_TICK, K_CTRL, K_PARAM, K_NONE} t_kind;

    typedef enum logic [2:0] {
        C_SINGLE_A, C_SINGLE_B, C_START, C_PAUSE, C_ABORT, C_OTHER
    } t_code;

    typedef struct packed {
        t_kind             kind;
        t_code             code;
        logic [2:0]        pmode;
        logic              psel;
        logic [5:0][7:0]   bytes;
    } t_item;

    typedef logic [NumBytes-1:0][7:0] t_tbytes;

endpackage

`default_nettype wire

/* rtl/core/fcps_front.sv */
// ----------------------------------------------------------------------------
// fcps_front
// Decode an incoming tick or frame into a classified item.
// ----------------------------------------------------------------------------
`default_nettype none

module fcps_front (
    input  wire logic           i_cmd,
    input  wire logic [10:0]    i_ident,
    input  wire logic [5:0][7:0] i_bytes,
    output fcps_pkg::t_item     o_item
);

    logic [10:0] base;
    logic        sel;
    logic        keep;
    logic [2:0]  pmode;

    always_comb begin
        base  = i_ident & ~fcps_pkg::ID_MASK;
        sel   = (i_ident & fcps_pkg::ID_MASK) == 11'd0;
        keep  = (i_ident & fcps_pkg::ID_MASK) == fcps_pkg::ID_MASK;
        pmode = 3'd0;
        if (base == fcps_pkg::ID_MODE1) pmode = 3'd1;
        else if (base == fcps_pkg::ID_MODE2) pmode = 3'd2;
        else if (base == fcps_pkg::ID_MODE3) pmode = 3'd3;
        else if (base == fcps_pkg::ID_MODE4) pmode = 3'd4;

        o_item.bytes = i_bytes;
        o_item.pmode = pmode;
        o_item.psel  = sel;
        case (i_bytes[0])
            fcps_pkg::CODE_SINGLE_A: o_item.code = fcps_pkg::C_SINGLE_A;
            fcps_pkg::CODE_SINGLE_B: o_item.code = fcps_pkg::C_SINGLE_B;
            fcps_pkg::CODE_START:    o_item.code = fcps_pkg::C_START;
            fcps_pkg::CODE_PAUSE:    o_item.code = fcps_pkg::C_PAUSE;
            fcps_pkg::CODE_ABORT:    o_item.code = fcps_pkg::C_ABORT;
            default:                 o_item.code = fcps_pkg::C_OTHER;
        endcase
        if (!i_cmd) o_item.kind = fcps_pkg::K_TICK;
        else if (i_ident == fcps_pkg::ID_CTRL) o_item.kind = fcps_pkg::K_CTRL;
        else if ((sel || keep) && pmode != 3'd0) o_item.kind = fcps_pkg::K_PARAM;
        else o_item.kind = fcps_pkg::K_NONE;
    end

endmodule

`default_nettype wire

/* rtl/core/fcps_queue.sv */
// ----------------------------------------------------------------------------
// fcps_queue
// Small item queue between the decode front and the sequencer back.
// ----------------------------------------------------------------------------
`default_nettype none

module fcps_queue #(
    parameter int unsigned DEPTH = fcps_pkg::QueueDepth
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fcps_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output fcps_pkg::t_item      o_item
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    fcps_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fcps_back.sv */
// ----------------------------------------------------------------------------
// fcps_back
// Sequencer: phase state, timing bytes, phase length counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcps_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire fcps_pkg::t_item i_item,
    output logic                 o_pop,
    output logic                 o_m_valid,
    input  wire logic            i_m_ready,
    output logic [2:0]           o_port,
    output logic                 o_repv,
    output logic [15:0]          o_repc,
    output logic                 o_run,
    output logic                 o_paused
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_LEAD_A, PH_SINGLE_A, PH_LEAD_B, PH_SINGLE_B, PH_START,
        PH_AB_FIRST, PH_AB_MID, PH_AB_SECOND, PH_AB_GAP,
        PH_T_LEAD, PH_T_IDLE1, PH_T_PAIR1, PH_T_GAP1, PH_T_IDLE2, PH_T_A, PH_T_GAP2,
        PH_Q_GAP1, PH_Q_PAIR2, PH_Q_GAP2, PH_Q_PAIR3
    } t_phase;

    typedef enum logic {B_RUN, B_WALK} t_bstate;

    typedef struct packed {
        t_phase ph;
        logic   rep;
        logic   clr;
    } t_np;

    function automatic logic [17:0] m1000(input logic [7:0] b);
        return 18'(b) * 18'd1000;
    endfunction

    function automatic logic [17:0] m100(input logic [7:0] b);
        return 18'(b) * 18'd100;
    endfunction

    function automatic logic [17:0] sat(input logic [17:0] a, input logic [17:0] b);
        return (a > b) ? a - b : 18'd0;
    endfunction

    function automatic logic [17:0] ab_off(input logic [2:0] m, input fcps_pkg::t_tbytes tb);
        logic [17:0] t;
        t = m100(tb[0]);
        if (m == 3'd1) return (t < 18'd50) ? 18'd50 : t;
        return 18'(tb[4]);
    endfunction

    function automatic logic [17:0] t_off(input logic [2:0] m, input fcps_pkg::t_tbytes tb);
        return (m == 3'd3) ? 18'(tb[8]) : 18'(tb[14]);
    endfunction

    function automatic logic [17:0] phase_len(input t_phase ph, input logic [2:0] m,
                                              input fcps_pkg::t_tbytes tb);
        logic [17:0] d;
        logic [17:0] len;
        d = ab_off(m, tb);
        case (ph)
            PH_LEAD_A, PH_SINGLE_A, PH_LEAD_B, PH_SINGLE_B, PH_T_LEAD, PH_T_A:
                len = 18'd50;
            PH_START:     len = 18'd200;
            PH_AB_FIRST:  len = (d >= 18'd50) ? 18'd50 : d + 18'd50;
            PH_AB_MID:    len = (d >= 18'd50) ? d - 18'd50 : 18'd0;
            PH_AB_SECOND: len = (d >= 18'd50) ? 18'd50 : 18'd0;
            PH_AB_GAP:
                len = (m == 3'd1) ? sat(sat(m1000(tb[1]), m100(tb[0])), 18'd50)
                                  : sat(m1000(tb[5]), 18'(tb[4]) + 18'd50);
            PH_T_IDLE1, PH_T_IDLE2:
                len = sat((m == 3'd3) ? 18'(tb[10]) : 18'(tb[16]), 18'd50);
            PH_T_PAIR1, PH_Q_PAIR2, PH_Q_PAIR3: len = t_off(m, tb) + 18'd50;
            PH_T_GAP1, PH_Q_GAP1, PH_Q_GAP2:
                len = sat(m1000((m == 3'd3) ? tb[9] : tb[15]), 18'd50 + t_off(m, tb));
            PH_T_GAP2: len = sat(m1000(tb[11]), 18'd50);
            default:   len = 18'd0;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] pulse(input logic [17:0] e, input logic [2:0] line);
        if (e < 18'd10) return line | fcps_pkg::STROBE;
        if (e < 18'd50) return line;
        return 3'd0;
    endfunction

    function automatic logic [2:0] pair(input logic [17:0] e, input logic [17:0] d);
        logic [2:0] p;
        p = pulse(e, fcps_pkg::LINE_A);
        if (e >= d) p = p | pulse(e - d, fcps_pkg::LINE_B);
        return p;
    endfunction

    function automatic logic [2:0] phase_port(input t_phase ph, input logic [17:0] e,
                                              input logic [2:0] m,
                                              input fcps_pkg::t_tbytes tb);
        logic [17:0] d;
        logic [2:0]  p;
        d = ab_off(m, tb);
        case (ph)
            PH_SINGLE_A, PH_T_A: p = pulse(e, fcps_pkg::LINE_A);
            PH_SINGLE_B, PH_AB_SECOND, PH_T_LEAD: p = pulse(e, fcps_pkg::LINE_B);
            PH_AB_FIRST: p = (d < 18'd50) ? pair(e, d) : pulse(e, fcps_pkg::LINE_A);
            PH_T_PAIR1, PH_Q_PAIR2, PH_Q_PAIR3: p = pair(e, t_off(m, tb));
            default: p = 3'd0;
        endcase
        return p;
    endfunction

    function automatic logic is_gap(input t_phase ph);
        return ph == PH_AB_MID || ph == PH_AB_GAP || ph == PH_T_GAP1 ||
               ph == PH_T_GAP2 || ph == PH_Q_GAP1 || ph == PH_Q_GAP2;
    endfunction

    function automatic t_np next_phase(input t_phase ph, input logic [2:0] m,
                                       input fcps_pkg::t_tbytes tb,
                                       input logic [15:0] cyc);
        t_np         r;
        logic [15:0] n;
        case (m)
            3'd1:    n = {tb[3], tb[2]};
            3'd2:    n = {tb[7], tb[6]};
            3'd3:    n = {tb[13], tb[12]};
            3'd4:    n = 16'd1;
            default: n = 16'd0;
        endcase
        r.ph  = PH_IDLE;
        r.rep = 1'b0;
        r.clr = 1'b0;
        case (ph)
            PH_LEAD_A: r.ph = PH_SINGLE_A;
            PH_LEAD_B: r.ph = PH_SINGLE_B;
            PH_START: begin
                r.clr = 1'b1;
                if (n == 16'd0) r.ph = PH_IDLE;
                else if (m == 3'd1)
                    r.ph = (m1000(tb[1]) > m100(tb[0])) ? PH_AB_FIRST : PH_IDLE;
                else if (m == 3'd2) r.ph = PH_AB_FIRST;
                else if (m == 3'd3 || m == 3'd4) r.ph = PH_T_LEAD;
            end
            PH_AB_FIRST:  r.ph = PH_AB_MID;
            PH_AB_MID:    r.ph = PH_AB_SECOND;
            PH_AB_SECOND: begin r.ph = PH_AB_GAP; r.rep = 1'b1; end
            PH_AB_GAP:    r.ph = (cyc < n) ? PH_AB_FIRST : PH_IDLE;
            PH_T_LEAD:    r.ph = PH_T_IDLE1;
            PH_T_IDLE1:   r.ph = PH_T_PAIR1;
            PH_T_PAIR1:   r.ph = (m == 3'd3) ? PH_T_GAP1 : PH_Q_GAP1;
            PH_T_GAP1:    r.ph = PH_T_IDLE2;
            PH_T_IDLE2:   r.ph = PH_T_A;
            PH_T_A:       begin r.ph = PH_T_GAP2; r.rep = 1'b1; end
            PH_T_GAP2:    r.ph = (cyc < n) ? PH_T_LEAD : PH_IDLE;
            PH_Q_GAP1:    r.ph = PH_Q_PAIR2;
            PH_Q_PAIR2:   r.ph = PH_Q_GAP2;
            PH_Q_GAP2:    r.ph = PH_Q_PAIR3;
            PH_Q_PAIR3:   begin r.ph = PH_IDLE; r.rep = 1'b1; end
            default:      r.ph = PH_IDLE;
        endcase
        return r;
    endfunction

    t_bstate           r_st, n_st;
    t_phase            r_ph, n_ph, r_cand, n_cand;
    logic [17:0]       r_left, n_left, r_len, n_len;
    logic [15:0]       r_cyc, n_cyc, r_repc, n_repc;
    logic              r_pause, n_pause, r_repv, n_repv;
    logic [2:0]        r_mode, n_mode;
    fcps_pkg::t_tbytes r_tb, n_tb;

    logic              r_o_valid;
    logic [2:0]        r_o_port;
    logic              r_o_repv, r_o_run, r_o_pause;
    logic [15:0]       r_o_repc;

    logic              slot_free, emit, walk;
    t_phase            np_in;
    t_np               np;
    logic [17:0]       clen, dec;
    logic [15:0]       cyc_base;

    assign slot_free = !r_o_valid || i_m_ready;
    assign np_in     = (r_st == B_RUN) ? r_ph : r_cand;
    assign np        = next_phase(np_in, r_mode, r_tb, r_cyc);
    assign clen      = phase_len(r_cand, r_mode, r_tb);
    assign dec       = (r_left != 18'd0) ? r_left - 18'd1 : 18'd0;
    assign cyc_base  = np.clr ? 16'd0 : r_cyc;

    always_comb begin
        n_st    = r_st;
        n_ph    = r_ph;
        n_cand  = r_cand;
        n_left  = r_left;
        n_len   = r_len;
        n_cyc   = r_cyc;
        n_pause = r_pause;
        n_mode  = r_mode;
        n_tb    = r_tb;
        n_repv  = r_repv;
        n_repc  = r_repc;
        o_pop   = 1'b0;
        emit    = 1'b0;
        walk    = 1'b0;
        case (r_st)
            B_RUN: begin
                if (i_valid && slot_free) begin
                    o_pop  = 1'b1;
                    n_repv = 1'b0;
                    n_repc = 16'd0;
                    case (i_item.kind)
                        fcps_pkg::K_TICK: begin
                            if (r_ph != PH_IDLE && !(r_pause && is_gap(r_ph))) begin
                                n_left = dec;
                                if (dec == 18'd0) begin
                                    walk   = 1'b1;
                                    n_cand = np.ph;
                                    n_cyc  = np.rep ? cyc_base + 16'd1 : cyc_base;
                                    if (np.rep) begin
                                        n_repv = 1'b1;
                                        n_repc = cyc_base + 16'd1;
                                    end
                                end
                            end
                        end
                        fcps_pkg::K_CTRL: begin
                            if (r_ph != PH_IDLE) begin
                                if (is_gap(r_ph)) begin
                                    if (i_item.code == fcps_pkg::C_ABORT) begin
                                        n_ph    = PH_IDLE;
                                        n_left  = 18'd0;
                                        n_pause = 1'b0;
                                    end else if (i_item.code == fcps_pkg::C_PAUSE && !r_pause)
                                        n_pause = 1'b1;
                                    else if (i_item.code == fcps_pkg::C_START && r_pause)
                                        n_pause = 1'b0;
                                end
                            end else begin
                                case (i_item.code)
                                    fcps_pkg::C_SINGLE_A: begin
                                        walk = 1'b1; n_cand = PH_LEAD_A;
                                    end
                                    fcps_pkg::C_SINGLE_B: begin
                                        walk = 1'b1; n_cand = PH_LEAD_B;
                                    end
                                    fcps_pkg::C_START: begin
                                        if (r_mode >= 3'd1 && r_mode <= 3'd4) begin
                                            walk   = 1'b1;
                                            n_cand = PH_START;
                                            n_cyc  = 16'd0;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        fcps_pkg::K_PARAM: begin
                            if (r_ph == PH_IDLE) begin
                                case (i_item.pmode)
                                    3'd1: begin
                                        n_tb[0] = i_item.bytes[0];
                                        n_tb[1] = i_item.bytes[1];
                                        n_tb[2] = i_item.bytes[4];
                                        n_tb[3] = i_item.bytes[5];
                                    end
                                    3'd2: begin
                                        n_tb[4] = i_item.bytes[0];
                                        n_tb[5] = i_item.bytes[1];
                                        n_tb[6] = i_item.bytes[4];
                                        n_tb[7] = i_item.bytes[5];
                                    end
                                    3'd3: begin
                                        n_tb[8]  = i_item.bytes[0];
                                        n_tb[9]  = i_item.bytes[1];
                                        n_tb[10] = i_item.bytes[2];
                                        n_tb[11] = i_item.bytes[3];
                                        n_tb[12] = i_item.bytes[4];
                                        n_tb[13] = i_item.bytes[5];
                                    end
                                    3'd4: begin
                                        n_tb[14] = i_item.bytes[0];
                                        n_tb[15] = i_item.bytes[1];
                                        n_tb[16] = i_item.bytes[2];
                                    end
                                    default: ;
                                endcase
                                if (i_item.psel) n_mode = i_item.pmode;
                            end
                        end
                        default: ;
                    endcase
                    if (walk) n_st = B_WALK;
                    else emit = 1'b1;
                end
            end
            B_WALK: begin
                if (slot_free) begin
                    if (r_cand == PH_IDLE) begin
                        n_ph    = PH_IDLE;
                        n_left  = 18'd0;
                        n_pause = 1'b0;
                        emit    = 1'b1;
                        n_st    = B_RUN;
                    end else if (clen != 18'd0) begin
                        n_ph   = r_cand;
                        n_left = clen;
                        n_len  = clen;
                        emit   = 1'b1;
                        n_st   = B_RUN;
                    end else begin
                        // zero-length phase: skip to its successor
                        n_cand = np.ph;
                        n_cyc  = np.rep ? cyc_base + 16'd1 : cyc_base;
                        if (np.rep) begin
                            n_repv = 1'b1;
                            n_repc = cyc_base + 16'd1;
                        end
                    end
                end
            end
            default: n_st = B_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= B_RUN;
            r_ph    <= PH_IDLE;
            r_cand  <= PH_IDLE;
            r_left  <= '0;
            r_len   <= '0;
            r_cyc   <= '0;
            r_pause <= 1'b0;
            r_mode  <= '0;
            r_repv  <= 1'b0;
            r_repc  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_ph    <= n_ph;
            r_cand  <= n_cand;
            r_left  <= n_left;
            r_len   <= n_len;
            r_cyc   <= n_cyc;
            r_pause <= n_pause;
            r_mode  <= n_mode;
            r_repv  <= n_repv;
            r_repc  <= n_repc;
            if (emit) r_o_valid <= 1'b1;
            else if (i_m_ready) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tb <= n_tb;
        if (emit) begin
            r_o_port  <= (n_ph == PH_IDLE) ? 3'd0
                       : phase_port(n_ph, n_len - n_left, r_mode, r_tb);
            r_o_repv  <= n_repv;
            r_o_repc  <= n_repc;
            r_o_run   <= n_ph != PH_IDLE;
            r_o_pause <= (n_ph != PH_IDLE) && n_pause;
        end
    end

    assign o_m_valid = r_o_valid;
    assign o_port    = r_o_port;
    assign o_repv    = r_o_repv;
    assign o_repc    = r_o_repc;
    assign o_run     = r_o_run;
    assign o_paused  = r_o_pause;

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_RUN && r_ph != PH_IDLE) |-> r_left != 18'd0)
        else $error("active phase with empty gap counter");

    a_pause_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_RUN && r_pause) |-> is_gap(r_ph))
        else $error("pause held outside a wait gap");

    a_report_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_repv) |-> r_o_repc != 16'd0)
        else $error("report with zero cycle number");

endmodule

`default_nettype wire

/* rtl/core/frame_commanded_pulse_sequencer_top.sv */
// ----------------------------------------------------------------------------
// frame_commanded_pulse_sequencer_top
// Tick and frame driven trigger sequencer with pulse patterns and reports.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while phases hold and results are taken;
//   an item that ends a phase or starts a pulse sends the back end into
//   its phase walker, which skips zero-length phases before the next item.
// Path: an accepted item is stored in the queue, popped by the back end and
//   its result held in the result register.
// Reset: synchronous, active low; clears queue, phase, counters and mode.
//   Timing bytes are not cleared and are undefined until written.
`default_nettype none

module frame_commanded_pulse_sequencer_top #(
    parameter int unsigned QUEUE_DEPTH = fcps_pkg::QueueDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // frame_ident[10:0], byte0[18:11], byte1 .. byte5 up to [58:51], zero fill
    input  wire logic [63:0] i_s_tdata,
    // cmd
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // port_bits[2:0], report_valid[3], report_count[19:4], running[20],
    // paused[21], zero fill
    output logic [23:0]      o_m_tdata
);

    fcps_pkg::t_item dec_item, q_item;
    logic            q_full, q_valid, pop, push;
    logic [2:0]      port;
    logic            repv, run, paused;
    logic [15:0]     repc;

    // Accept whenever the queue has room; the back end drains it.
    assign o_s_tready = !q_full;
    assign push       = i_s_tvalid && !q_full;

    fcps_front u_front (
        .i_cmd   (i_s_tuser),
        .i_ident (i_s_tdata[10:0]),
        .i_bytes (i_s_tdata[58:11]),
        .o_item  (dec_item)
    );

    fcps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (dec_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back end: run the phase machine and hold the result register.
    fcps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .o_port    (port),
        .o_repv    (repv),
        .o_repc    (repc),
        .o_run     (run),
        .o_paused  (paused)
    );

    assign o_m_tdata = {2'b00, paused, run, repc, repv, port};

endmodule

`default_nettype wire

/* tb/frame_commanded_pulse_sequencer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_commanded_pulse_sequencer_checker
// Watches both stream channels and predicts the trigger port, the cycle
// reports and the run and pause flags for every accepted item. It compares
// them field by field, in order, with the results that the block returns.
// ----------------------------------------------------------------------------
module frame_commanded_pulse_sequencer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_report_count
);
    import fcps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_LEAD_A, S_ONE_A, S_LEAD_B, S_ONE_B, S_START,
        S_AB_FIRST, S_AB_MID, S_AB_SECOND, S_AB_GAP,
        S_T_LEAD, S_T_IDLE1, S_T_PAIR1, S_T_GAP1, S_T_IDLE2, S_T_A, S_T_GAP2,
        S_Q_GAP1, S_Q_PAIR2, S_Q_GAP2, S_Q_PAIR3
    } t_seq;

    typedef struct packed {
        logic        paused;
        logic        running;
        logic [15:0] count;
        logic        rep;
        logic [2:0]  port;
    } t_trigger_out;

    logic [2:0]  mode_sel;
    logic [7:0]  tbytes [NumBytes];
    t_seq        seq;
    int unsigned units_left;
    logic [15:0] cycle_no;
    logic        hold;
    logic        rep_v;
    logic [15:0] rep_n;

    t_trigger_out trigger_q [$];

    function automatic int unsigned tb8(int i);
        return tbytes[i];
    endfunction

    function automatic int unsigned sat(int unsigned a, int unsigned b);
        return a > b ? a - b : 0;
    endfunction

    function automatic int unsigned mode_cycles();
        case (mode_sel)
            3'd1: return {tbytes[3], tbytes[2]};
            3'd2: return {tbytes[7], tbytes[6]};
            3'd3: return {tbytes[13], tbytes[12]};
            3'd4: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned ab_offset();
        int unsigned t;
        if (mode_sel == 3'd1) begin
            t = tb8(0) * 100;
            return t < 50 ? 50 : t;
        end
        return tb8(4);
    endfunction

    function automatic int unsigned ab_gap();
        if (mode_sel == 3'd1) return sat(sat(tb8(1) * 1000, tb8(0) * 100), 50);
        return sat(tb8(5) * 1000, tb8(4) + 50);
    endfunction

    function automatic int unsigned train_offset();
        return mode_sel == 3'd3 ? tb8(8) : tb8(14);
    endfunction

    function automatic int unsigned train_lead();
        return sat(mode_sel == 3'd3 ? tb8(10) : tb8(16), 50);
    endfunction

    function automatic int unsigned train_gap();
        if (mode_sel == 3'd3) return sat(tb8(9) * 1000, 50 + tb8(8));
        return sat(tb8(15) * 1000, 50 + tb8(14));
    endfunction

    function automatic logic [2:0] pulse(int unsigned e, logic [2:0] line);
        if (e < 10) return line | STROBE;
        if (e < 50) return line;
        return 3'b000;
    endfunction

    function automatic logic [2:0] pair(int unsigned e, int unsigned d);
        logic [2:0] p;
        p = pulse(e, LINE_A);
        if (e >= d) p |= pulse(e - d, LINE_B);
        return p;
    endfunction

    function automatic int unsigned seq_len(t_seq s);
        int unsigned d;
        d = ab_offset();
        case (s)
            S_LEAD_A, S_ONE_A, S_LEAD_B, S_ONE_B, S_T_LEAD, S_T_A: return 50;
            S_START: return 200;
            S_AB_FIRST: return d >= 50 ? 50 : d + 50;
            S_AB_MID: return d >= 50 ? d - 50 : 0;
            S_AB_SECOND: return d >= 50 ? 50 : 0;
            S_AB_GAP: return ab_gap();
            S_T_IDLE1, S_T_IDLE2: return train_lead();
            S_T_PAIR1, S_Q_PAIR2, S_Q_PAIR3: return train_offset() + 50;
            S_T_GAP1, S_Q_GAP1, S_Q_GAP2: return train_gap();
            S_T_GAP2: return sat(tb8(11) * 1000, 50);
            default: return 0;
        endcase
    endfunction

    function automatic logic [2:0] seq_port(t_seq s, int unsigned e);
        int unsigned d;
        d = ab_offset();
        case (s)
            S_ONE_A, S_T_A: return pulse(e, LINE_A);
            S_ONE_B, S_AB_SECOND, S_T_LEAD: return pulse(e, LINE_B);
            S_AB_FIRST: return d < 50 ? pair(e, d) : pulse(e, LINE_A);
            S_T_PAIR1, S_Q_PAIR2, S_Q_PAIR3: return pair(e, train_offset());
            default: return 3'b000;
        endcase
    endfunction

    function automatic logic in_gap(t_seq s);
        return s inside {S_AB_MID, S_AB_GAP, S_T_GAP1, S_T_GAP2, S_Q_GAP1, S_Q_GAP2};
    endfunction

    function automatic t_seq report_and(t_seq nxt);
        cycle_no = cycle_no + 16'd1;
        rep_v = 1'b1;
        rep_n = cycle_no;
        return nxt;
    endfunction

    function automatic t_seq advance(t_seq s);
        int unsigned n;
        n = mode_cycles();
        case (s)
            S_LEAD_A: return S_ONE_A;
            S_LEAD_B: return S_ONE_B;
            S_START: begin
                cycle_no = '0;
                if (n == 0) return S_IDLE;
                if (mode_sel == 3'd1) return tb8(1) * 1000 > tb8(0) * 100 ? S_AB_FIRST : S_IDLE;
                if (mode_sel == 3'd2) return S_AB_FIRST;
                if (mode_sel == 3'd3 || mode_sel == 3'd4) return S_T_LEAD;
                return S_IDLE;
            end
            S_AB_FIRST: return S_AB_MID;
            S_AB_MID: return S_AB_SECOND;
            S_AB_SECOND: return report_and(S_AB_GAP);
            S_AB_GAP: return cycle_no < n ? S_AB_FIRST : S_IDLE;
            S_T_LEAD: return S_T_IDLE1;
            S_T_IDLE1: return S_T_PAIR1;
            S_T_PAIR1: return mode_sel == 3'd3 ? S_T_GAP1 : S_Q_GAP1;
            S_T_GAP1: return S_T_IDLE2;
            S_T_IDLE2: return S_T_A;
            S_T_A: return report_and(S_T_GAP2);
            S_T_GAP2: return cycle_no < n ? S_T_LEAD : S_IDLE;
            S_Q_GAP1: return S_Q_PAIR2;
            S_Q_PAIR2: return S_Q_GAP2;
            S_Q_GAP2: return S_Q_PAIR3;
            S_Q_PAIR3: return report_and(S_IDLE);
            default: return S_IDLE;
        endcase
    endfunction

    // Walk through zero-length phases until one with time in it.
    function automatic void enter(t_seq s);
        int unsigned len;
        for (int g = 0; g < 32; g++) begin
            if (s == S_IDLE) break;
            len = seq_len(s);
            if (len > 0) begin
                seq = s;
                units_left = len & 32'h3FFFF;
                return;
            end
            s = advance(s);
        end
        seq = S_IDLE;
        units_left = 0;
        hold = 1'b0;
    endfunction

    function automatic void store_bytes(int base, logic [5:0][7:0] b, int cnt, logic counts);
        for (int k = 0; k < cnt; k++) tbytes[base + k] = b[k];
        if (counts) begin
            tbytes[base + cnt]     = b[4];
            tbytes[base + cnt + 1] = b[5];
        end
    endfunction

    function automatic t_trigger_out predict_trigger(logic is_frame, logic [63:0] d);
        logic [10:0]     ident;
        logic [5:0][7:0] b;
        logic [10:0]     base;
        logic            sel;
        logic            keep;
        t_trigger_out    r;
        ident = d[10:0];
        b     = d[58:11];
        rep_v = 1'b0;
        rep_n = '0;
        if (!is_frame) begin
            if (seq != S_IDLE && !(hold && in_gap(seq))) begin
                if (units_left > 0) units_left--;
                if (units_left == 0) enter(advance(seq));
            end
        end else if (seq != S_IDLE) begin
            if (ident == ID_CTRL && in_gap(seq)) begin
                if (b[0] == CODE_ABORT) begin
                    seq = S_IDLE;
                    units_left = 0;
                    hold = 1'b0;
                end else if (b[0] == CODE_PAUSE && !hold) begin
                    hold = 1'b1;
                end else if (b[0] == CODE_START && hold) begin
                    hold = 1'b0;
                end
            end
        end else if (ident == ID_CTRL) begin
            if (b[0] == CODE_SINGLE_A) enter(S_LEAD_A);
            else if (b[0] == CODE_SINGLE_B) enter(S_LEAD_B);
            else if (b[0] == CODE_START && mode_sel >= 3'd1 && mode_sel <= 3'd4) begin
                cycle_no = '0;
                enter(S_START);
            end
        end else begin
            base = ident & ~ID_MASK;
            sel  = (ident & ID_MASK) == '0;
            keep = (ident & ID_MASK) == ID_MASK;
            if (sel || keep) begin
                if (base == ID_MODE1) begin
                    store_bytes(0, b, 2, 1'b1);
                    if (sel) mode_sel = 3'd1;
                end else if (base == ID_MODE2) begin
                    store_bytes(4, b, 2, 1'b1);
                    if (sel) mode_sel = 3'd2;
                end else if (base == ID_MODE3) begin
                    store_bytes(8, b, 4, 1'b1);
                    if (sel) mode_sel = 3'd3;
                end else if (base == ID_MODE4) begin
                    store_bytes(14, b, 3, 1'b0);
                    if (sel) mode_sel = 3'd4;
                end
            end
        end
        r.running = seq != S_IDLE;
        r.paused  = r.running && hold;
        r.port    = r.running ? seq_port(seq, seq_len(seq) - units_left) : 3'b000;
        r.rep     = rep_v;
        r.count   = rep_n;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_trigger_out want;
        t_trigger_out got;
        if (!i_rst_n) begin
            mode_sel = '0;
            seq = S_IDLE;
            units_left = 0;
            cycle_no = '0;
            hold = 1'b0;
            trigger_q.delete();
            o_fail_count = 0;
            o_report_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) trigger_q.push_back(predict_trigger(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[21:0];
                if (got.rep) o_report_count++;
                if (trigger_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected result %h", i_m_tdata);
                end else begin
                    want = trigger_q.pop_front();
                    if (want.port != got.port || want.rep != got.rep || want.count != got.count
                        || want.running != got.running || want.paused != got.paused
                        || i_m_tdata[23:22] != 2'b00) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: exp port %b rep %b cnt %0d run %b pause %b, got port %b rep %b cnt %0d run %b pause %b (%h)",
                                     want.port, want.rep, want.count, want.running, want.paused,
                                     got.port, got.rep, got.count, got.running, got.paused,
                                     i_m_tdata);
                    end
                end
            end
        end
        o_pending = trigger_q.size();
    end

endmodule

/* tb/frame_commanded_pulse_sequencer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_commanded_pulse_sequencer_top_tb
// Drives ticks and frames into the pulse sequencer: a directed opening over
// every identifier and control code, then mode runs with random timing,
// pause, resume and abort frames and noise, under several idling patterns.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module frame_commanded_pulse_sequencer_top_tb;
    import fcps_pkg::*;

    localparam int RandomItems = 1650;
    localparam int CycleLimit  = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // frame_ident, byte0 .. byte5, zero fill
    logic        i_s_tuser;   // cmd
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // port_bits, report_valid, report_count, running, paused

    int fail_count;
    int pending;
    int report_count;
    int cycles;
    int items_sent;
    int mode_starts;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;

    frame_commanded_pulse_sequencer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    frame_commanded_pulse_sequencer_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tuser      (i_s_tuser),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_report_count (report_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stop a hung run.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAIL frame_commanded_pulse_sequencer_top");
                $finish;
            end
        end
    end

    // Receiver: stall at random, or hold off entirely while a long stall is asked.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    // Offer one item after a random idle stretch; return once it is accepted.
    task automatic offer_item(logic is_frame, logic [10:0] ident, logic [5:0][7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= is_frame;
        i_s_tdata  <= {5'b0, b, ident};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic tick();
        offer_item(1'b0, 11'($urandom), 48'({$urandom, $urandom}));
    endtask

    task automatic control(logic [7:0] code);
        logic [5:0][7:0] b;
        b = 48'({$urandom, $urandom});
        b[0] = code;
        offer_item(1'b1, ID_CTRL, b);
    endtask

    // Load timing bytes of mode m; short timings most of the time.
    task automatic load_mode(int m, logic select);
        logic [5:0][7:0] b;
        logic [10:0]     ident;
        b[0] = 8'($urandom_range(0, 12));
        b[1] = 8'($urandom_range(0, 3) == 0 ? 1 : 0);
        b[2] = 8'($urandom_range(0, 120));
        b[3] = 8'($urandom_range(0, 3) == 0 ? 1 : 0);
        b[4] = 8'($urandom_range(0, 3));
        b[5] = 8'($urandom_range(0, 7) == 0 ? $urandom_range(0, 255) : 0);
        if (m == 2) begin
            b[0] = 8'($urandom_range(0, 90));
            b[1] = 8'($urandom_range(0, 2) == 0 ? 1 : 0);
        end
        if (m == 4) b[1] = 8'($urandom_range(0, 3) == 0 ? 1 : 0);
        if ($urandom_range(0, 9) == 0) b = 48'({$urandom, $urandom});
        case (m)
            1: ident = ID_MODE1;
            2: ident = ID_MODE2;
            3: ident = ID_MODE3;
            default: ident = ID_MODE4;
        endcase
        offer_item(1'b1, select ? ident : ident | ID_MASK, b);
    endtask

    // Run a selected mode: ticks with a few commands and noise frames mixed in.
    task automatic mode_run(int span);
        int r;
        control(CODE_START);
        mode_starts++;
        for (int k = 0; k < span; k++) begin
            r = $urandom_range(0, 99);
            if (r < 2) control(CODE_PAUSE);
            else if (r < 4) control(CODE_START);
            else if (r == 4) control(CODE_ABORT);
            else if (r == 5) offer_item(1'b1, 11'($urandom), 48'({$urandom, $urandom}));
            else tick();
        end
    endtask

    task automatic random_part(int count);
        int target;
        int r;
        target = items_sent + count;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                load_mode($urandom_range(1, 4), 1'b1);
                mode_run($urandom_range(20, 350));
            end else if (r < 70) begin
                control($urandom_range(0, 1) ? CODE_SINGLE_A : CODE_SINGLE_B);
                repeat ($urandom_range(5, 60)) tick();
            end else if (r < 80) begin
                load_mode($urandom_range(1, 4), 1'b0);
            end else begin
                // noise: any frame, any code
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 1)) control(8'($urandom));
                    else offer_item($urandom_range(0, 1), 11'($urandom),
                                    48'({$urandom, $urandom}));
                end
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tuser   = 1'b0;
        i_s_tdata   = '0;
        items_sent  = 0;
        mode_starts = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle codes with no mode chosen, then every identifier.
        control(CODE_START);
        control(CODE_PAUSE);
        control(CODE_ABORT);
        control(8'h00);
        offer_item(1'b1, ID_MODE1 | ID_MASK, 48'hFF_FF_FF_FF_FF_FF);
        offer_item(1'b1, ID_MODE2 | ID_MASK, 48'h00_00_FF_FF_FF_FF);
        offer_item(1'b1, ID_MODE3 | ID_MASK, 48'hFF_FF_00_00_00_00);
        offer_item(1'b1, ID_MODE4 | ID_MASK, 48'h00_00_00_FF_00_FF);
        offer_item(1'b1, ID_MODE1 | 11'd1, 48'h0);
        offer_item(1'b1, 11'h7FF, 48'hFF_FF_FF_FF_FF_FF);
        // Overlapping single pulses; the second frame lands outside a gap.
        control(CODE_SINGLE_A);
        control(CODE_SINGLE_B);
        repeat (3) tick();
        // Mode 2 with a small offset; mode 1 with no room to run.
        offer_item(1'b1, ID_MODE2, {8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd20});
        offer_item(1'b1, ID_MODE1, {8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd10});
        offer_item(1'b1, ID_MODE3, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        offer_item(1'b1, ID_MODE4, {8'd0, 8'd0, 8'd0, 8'd60, 8'd0, 8'd0});
        offer_item(1'b1, ID_MODE2, {8'd0, 8'd1, 8'd0, 8'd0, 8'd1, 8'd55});

        // Four idling phases, the long receiver hold-off in the third.
        random_part(RandomItems / 4);
        send_idle_pct  = 72;
        random_part(RandomItems / 4);
        send_idle_pct  = 0;
        recv_stall_pct = 72;
        hold_off_cycles = 400;
        random_part(RandomItems / 4);
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        random_part(RandomItems / 4);
        i_s_tvalid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle.
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d items, %0d mode starts, %0d cycle reports",
                 items_sent, mode_starts, report_count);
        if (fail_count == 0) begin
            $display("PASS frame_commanded_pulse_sequencer_top");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAIL frame_commanded_pulse_sequencer_top");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/fcps_pkg.sv
rtl/core/fcps_front.sv
rtl/core/fcps_queue.sv
rtl/core/fcps_back.sv
rtl/core/frame_commanded_pulse_sequencer_top.sv
tb/frame_commanded_pulse_sequencer_checker.sv
tb/frame_commanded_pulse_sequencer_top_tb.sv
